// ----- rtl/asfphp_pkg.sv -----
// Package for the ASF data packet header parser.
// Holds the word types of both channels, the phase and field codes and small helpers.
// No dependencies; used by asf_packet_header_parser_top.
`default_nettype none

package asfphp_pkg;

    // Width used when a length counter is compared against a 32-bit field value.
    localparam int CMP_W = 33;

    typedef struct packed {
        logic [7:0]  data_byte;
        logic        first_byte;
        logic [15:0] buffer_length;
    } t_in_word;

    typedef struct packed {
        logic        result_kind;
        logic [6:0]  stream_number;
        logic        key_frame;
        logic [31:0] object_number;
        logic [31:0] object_offset;
        logic [31:0] object_size;
        logic [31:0] time_ms;
        logic        time_valid;
        logic [7:0]  duration_ms;
        logic [15:0] payload_start;
        logic [15:0] payload_length;
        logic [1:0]  status;
    } t_out_word;

    typedef enum logic [4:0] {
        PH_IDLE,
        PH_EC,
        PH_FLAGS1,
        PH_PROP,
        PH_VAR,
        PH_SEND,
        PH_COUNT,
        PH_STREAM,
        PH_REP,
        PH_DATA,
        PH_SUBLEN,
        PH_SUBDATA,
        PH_DONE
    } t_phase;

    typedef enum logic [2:0] {
        FLD_PKTLEN,
        FLD_SEQ,
        FLD_PAD,
        FLD_MONUM,
        FLD_MOOFF,
        FLD_REPLEN,
        FLD_PLEN
    } t_field;

    typedef enum logic [1:0] {
        CFG_NOMINAL_SIZE,
        CFG_PREROLL
    } t_cfg_reg;

    localparam logic [1:0] ST_NONE        = 2'd0;
    localparam logic [1:0] ST_RECOVERABLE = 2'd1;
    localparam logic [1:0] ST_FATAL       = 2'd2;

    localparam logic KIND_DESCRIPTOR = 1'b0;
    localparam logic KIND_STATUS     = 1'b1;

    localparam logic [7:0] EC_PRESENT_MASK = 8'h80;
    localparam logic [7:0] EC_TYPE_MASK    = 8'h60;
    localparam logic [7:0] EC_LEN_MASK     = 8'h0f;
    localparam logic [7:0] STREAM_MASK     = 8'h7f;
    localparam logic [7:0] COUNT_MASK      = 8'h3f;
    localparam logic [7:0] LENTYPE_MASK    = 8'hc0;

    localparam int MIN_BUFFER = 8;
    localparam int SEND_BYTES = 6;

    // Byte count of a variable-length field from its two-bit length type.
    function automatic logic [2:0] varlen_bytes(input logic [1:0] code);
        logic [2:0] n;
        case (code)
            2'd0:    n = 3'd0;
            2'd1:    n = 3'd1;
            2'd2:    n = 3'd2;
            default: n = 3'd4;
        endcase
        return n;
    endfunction

    // Timestamp minus preroll, clamped at zero.
    function automatic logic [31:0] after_preroll(input logic [31:0] t, input logic [31:0] p);
        return (t < p) ? 32'd0 : t - p;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/asf_packet_header_parser_top.sv -----
// ASF data packet header parser, top level.
// Decodes one buffer byte per word and emits payload descriptors and a final status.
// Depends on asfphp_pkg.
//
//   channel | direction | handshake               | word
//   --------+-----------+-------------------------+------------------------
//   in      | input     | i_in_valid / o_in_stall | asfphp_pkg::t_in_word
//   out     | output    | o_out_valid / i_out_stall | asfphp_pkg::t_out_word
//   cfg     | input     | i_cfg_we                | index + 32-bit data
//
// One input word is taken every cycle; its result, if any, is in the output register
// on the next cycle. The whole decode of a byte is one combinational pass from the
// parser state registers into the output register.
// Reset (i_rst_n low, synchronous) returns the parser to idle and clears the
// configuration registers; no clearing pass is needed.
// The input stalls only while a result waits in the output register and the output
// is stalled.
`default_nettype none

module asf_packet_header_parser_top #(
    parameter int REP_DATA_KEEP = 8,
    parameter int LENGTH_BITS   = 16
) (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  asfphp_pkg::t_in_word   i_in_word,
    output logic                   o_out_valid,
    input  wire                    i_out_stall,
    output asfphp_pkg::t_out_word  o_out_word,
    input  wire                    i_cfg_we,
    input  wire [1:0]              i_cfg_index,
    input  wire [31:0]             i_cfg_wdata
);

    localparam int LW = LENGTH_BITS;
    localparam int CW = asfphp_pkg::CMP_W;

    // Configuration
    logic [15:0] r_nominal;
    logic [31:0] r_preroll;

    // Parser state
    asfphp_pkg::t_phase r_phase, n_phase;
    asfphp_pkg::t_field r_fid, n_fid;
    logic [LW-1:0] r_bpos, n_bpos;
    logic [LW-1:0] r_last, n_last;
    logic [LW-1:0] r_left, n_left;
    logic [LW-1:0] r_skip, n_skip;
    logic [31:0]   r_acc, n_acc;
    logic [2:0]    r_fbl, n_fbl;
    logic [1:0]    r_shift, n_shift;
    logic [7:0]    r_lflags, n_lflags;
    logic [7:0]    r_pflags, n_pflags;
    logic [5:0]    r_count, n_count;
    logic [5:0]    r_index, n_index;
    logic [31:0]   r_hf0, n_hf0;
    logic [31:0]   r_hf1, n_hf1;
    logic [31:0]   r_hf2, n_hf2;
    logic [31:0]   r_hf3, n_hf3;
    logic [LW-1:0] r_hf4, n_hf4;
    logic [LW-1:0] r_hf5, n_hf5;
    logic [7:0]    r_rep [REP_DATA_KEEP];
    logic [7:0]    n_rep [REP_DATA_KEEP];
    logic [31:0]   r_subt, n_subt;
    logic [1:0]    r_err, n_err;
    logic [7:0]    r_stream, n_stream;
    logic          r_multi, n_multi;
    logic [1:0]    r_mlt, n_mlt;

    // Output register
    asfphp_pkg::t_out_word r_out, n_out;
    logic r_out_valid;

    // Decode controls
    logic           in_acc;
    logic           proc;
    logic           do_consume, do_begin, do_end, do_after_rep, do_body;
    logic           do_next, do_start, do_after_sub, do_after_header;
    asfphp_pkg::t_field bf_id, end_id;
    logic [31:0]    end_v;
    logic [1:0]     lt;
    logic [2:0]     flen;
    logic [LW-1:0]  blen;
    logic [3:0]     ec_len;
    logic [LW-1:0]  rep_idx;
    logic [32:0]    sub_sum;
    logic [LW-1:0]  need;
    logic           e_emit, e_status, e_tvalid;
    logic [31:0]    e_size, e_time;
    logic [7:0]     e_dur;
    logic [LW-1:0]  e_len;
    logic [CW-1:0]  pos_next;
    logic [7:0]     b;

    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = r_out_valid && i_out_stall;
    assign b          = i_in_word.data_byte;

    // Next state: one pass through the byte decode.
    always_comb begin
        n_phase  = r_phase;   n_fid    = r_fid;    n_bpos   = r_bpos;
        n_last   = r_last;    n_left   = r_left;   n_skip   = r_skip;
        n_acc    = r_acc;     n_fbl    = r_fbl;    n_shift  = r_shift;
        n_lflags = r_lflags;  n_pflags = r_pflags; n_count  = r_count;
        n_index  = r_index;   n_hf0    = r_hf0;    n_hf1    = r_hf1;
        n_hf2    = r_hf2;     n_hf3    = r_hf3;    n_hf4    = r_hf4;
        n_hf5    = r_hf5;     n_rep    = r_rep;    n_subt   = r_subt;
        n_err    = r_err;     n_stream = r_stream; n_multi  = r_multi;
        n_mlt    = r_mlt;
        proc = 1'b0;  do_consume = 1'b0; do_begin = 1'b0; do_end = 1'b0;
        do_after_rep = 1'b0; do_body = 1'b0; do_next = 1'b0; do_start = 1'b0;
        do_after_sub = 1'b0; do_after_header = 1'b0;
        bf_id = asfphp_pkg::FLD_PKTLEN; end_id = asfphp_pkg::FLD_PKTLEN;
        end_v = 32'd0; lt = 2'd0; flen = 3'd0; rep_idx = '0; sub_sum = '0; need = '0;
        e_emit = 1'b0; e_status = 1'b0; e_tvalid = 1'b0; e_size = 32'd0;
        e_time = 32'd0; e_dur = 8'd0; e_len = '0;
        blen   = LW'(i_in_word.buffer_length);
        ec_len = 4'd0;

        if (in_acc && i_in_word.first_byte) begin
            proc    = 1'b1;
            n_bpos  = '0;
            n_last  = (blen == '0) ? '0 : blen - 1'b1;
            n_err   = asfphp_pkg::ST_NONE;
            n_left  = '0;
            n_skip  = '0;
            n_multi = 1'b0;
            n_count = '0;
            n_index = '0;
            if (CW'(blen) < CW'(asfphp_pkg::MIN_BUFFER)) begin
                n_err   = asfphp_pkg::ST_RECOVERABLE;
                n_phase = asfphp_pkg::PH_DONE;
            end else if ((b & asfphp_pkg::EC_PRESENT_MASK) != 8'd0) begin
                ec_len = ((b & asfphp_pkg::EC_TYPE_MASK) == 8'd0) ?
                         4'(b & asfphp_pkg::EC_LEN_MASK) : 4'd2;
                if (CW'(blen) <= CW'(ec_len) + CW'(9)) begin
                    n_err   = asfphp_pkg::ST_FATAL;
                    n_phase = asfphp_pkg::PH_DONE;
                end else begin
                    n_left = LW'(CW'(blen) - CW'(ec_len) - CW'(1));
                    if (ec_len == 4'd0) begin
                        n_phase = asfphp_pkg::PH_FLAGS1;
                    end else begin
                        n_skip  = LW'(ec_len);
                        n_phase = asfphp_pkg::PH_EC;
                    end
                end
            end else begin
                n_left     = blen;
                n_phase    = asfphp_pkg::PH_FLAGS1;
                do_consume = 1'b1;
            end
        end else if (in_acc && r_phase != asfphp_pkg::PH_IDLE) begin
            proc       = 1'b1;
            n_bpos     = r_bpos + 1'b1;
            do_consume = 1'b1;
        end

        if (do_consume) begin
            if (n_phase != asfphp_pkg::PH_EC && n_left != '0) begin
                n_left = n_left - 1'b1;
            end
            unique case (n_phase)
                asfphp_pkg::PH_EC: begin
                    n_skip = n_skip - 1'b1;
                    if (n_skip == '0) begin
                        n_phase = asfphp_pkg::PH_FLAGS1;
                    end
                end
                asfphp_pkg::PH_FLAGS1: begin
                    n_lflags = b;
                    n_phase  = asfphp_pkg::PH_PROP;
                end
                asfphp_pkg::PH_PROP: begin
                    n_pflags = b;
                    do_begin = 1'b1;
                    bf_id    = asfphp_pkg::FLD_PKTLEN;
                end
                asfphp_pkg::PH_VAR: begin
                    n_acc   = n_acc | (32'(b) << {n_shift, 3'b000});
                    n_shift = n_shift + 1'b1;
                    n_fbl   = n_fbl - 1'b1;
                    if (n_fbl == 3'd0) begin
                        do_end = 1'b1;
                        end_id = n_fid;
                        end_v  = n_acc;
                    end
                end
                asfphp_pkg::PH_SEND: begin
                    n_skip = n_skip - 1'b1;
                    if (n_skip == '0) begin
                        do_after_header = 1'b1;
                    end
                end
                asfphp_pkg::PH_COUNT: begin
                    n_count = 6'(b & asfphp_pkg::COUNT_MASK);
                    n_mlt   = 2'((b & asfphp_pkg::LENTYPE_MASK) >> 6);
                    n_multi = 1'b1;
                    n_index = '0;
                    if (n_count == '0) begin
                        n_phase = asfphp_pkg::PH_DONE;
                    end else begin
                        do_start = 1'b1;
                    end
                end
                asfphp_pkg::PH_STREAM: begin
                    n_stream = b;
                    do_begin = 1'b1;
                    bf_id    = asfphp_pkg::FLD_MONUM;
                end
                asfphp_pkg::PH_REP: begin
                    rep_idx = n_hf4 - n_skip;
                    for (int k = 0; k < REP_DATA_KEEP; k++) begin
                        if (CW'(rep_idx) == CW'(k)) begin
                            n_rep[k] = b;
                        end
                    end
                    n_skip = n_skip - 1'b1;
                    if (n_skip == '0) begin
                        do_after_rep = 1'b1;
                    end
                end
                asfphp_pkg::PH_DATA: begin
                    n_skip = n_skip - 1'b1;
                    if (n_skip == '0) begin
                        do_next = 1'b1;
                    end
                end
                asfphp_pkg::PH_SUBLEN: begin
                    n_hf5 = n_hf5 - 1'b1;
                    if (CW'(n_hf5) < CW'(b)) begin
                        n_err   = n_multi ? asfphp_pkg::ST_FATAL : asfphp_pkg::ST_RECOVERABLE;
                        n_phase = asfphp_pkg::PH_DONE;
                    end else if (b != 8'd0) begin
                        e_emit   = 1'b1;
                        e_size   = 32'd0;
                        e_time   = n_subt;
                        e_tvalid = 1'b1;
                        e_dur    = n_rep[0];
                        e_len    = LW'(b);
                        n_skip   = LW'(b);
                        n_phase  = asfphp_pkg::PH_SUBDATA;
                    end else begin
                        do_after_sub = 1'b1;
                    end
                end
                asfphp_pkg::PH_SUBDATA: begin
                    n_hf5  = n_hf5 - 1'b1;
                    n_skip = n_skip - 1'b1;
                    if (n_skip == '0) begin
                        do_after_sub = 1'b1;
                    end
                end
                default: begin
                end
            endcase
        end

        if (do_after_sub) begin
            sub_sum = {1'b0, n_subt} + 33'(n_rep[0]);
            n_subt  = sub_sum[32] ? 32'hffff_ffff : sub_sum[31:0];
            if (n_hf5 == '0) begin
                do_next = 1'b1;
            end else begin
                n_phase = asfphp_pkg::PH_SUBLEN;
            end
        end

        if (do_after_header) begin
            if (CW'(n_left) < CW'(n_hf1)) begin
                n_err   = asfphp_pkg::ST_RECOVERABLE;
                n_phase = asfphp_pkg::PH_DONE;
            end else begin
                n_left = n_left - LW'(n_hf1);
                if (n_hf0 != 32'd0 && n_hf1 == 32'd0 && n_hf0 < 32'(r_nominal)) begin
                    need = LW'(32'(r_nominal) - n_hf0);
                    // Implicit padding is only taken when the whole gap is still left.
                    if (CW'(n_left) < CW'(32'(r_nominal) - n_hf0)) begin
                        n_err   = asfphp_pkg::ST_RECOVERABLE;
                        n_phase = asfphp_pkg::PH_DONE;
                    end else begin
                        n_left = n_left - need;
                    end
                end
                if (n_phase != asfphp_pkg::PH_DONE) begin
                    if (n_lflags[0]) begin
                        if (n_left == '0) begin
                            n_err   = asfphp_pkg::ST_RECOVERABLE;
                            n_phase = asfphp_pkg::PH_DONE;
                        end else begin
                            n_phase = asfphp_pkg::PH_COUNT;
                        end
                    end else begin
                        n_multi  = 1'b0;
                        n_count  = 6'd1;
                        n_index  = '0;
                        do_start = 1'b1;
                    end
                end
            end
        end

        // Zero-length fields fall straight through to the next one, so a single byte
        // can close up to four header fields.
        for (int k = 0; k < 5; k++) begin
            if (do_begin) begin
                do_begin = 1'b0;
                case (bf_id)
                    asfphp_pkg::FLD_PKTLEN: lt = n_lflags[6:5];
                    asfphp_pkg::FLD_SEQ:    lt = n_lflags[2:1];
                    asfphp_pkg::FLD_PAD:    lt = n_lflags[4:3];
                    asfphp_pkg::FLD_MONUM:  lt = n_pflags[5:4];
                    asfphp_pkg::FLD_MOOFF:  lt = n_pflags[3:2];
                    asfphp_pkg::FLD_REPLEN: lt = n_pflags[1:0];
                    default:                lt = n_mlt;
                endcase
                flen = asfphp_pkg::varlen_bytes(lt);
                if (flen == 3'd0) begin
                    do_end = 1'b1;
                    end_id = bf_id;
                    end_v  = 32'd0;
                end else if (CW'(n_left) < CW'(flen)) begin
                    if (bf_id == asfphp_pkg::FLD_PKTLEN || bf_id == asfphp_pkg::FLD_SEQ ||
                        bf_id == asfphp_pkg::FLD_PAD) begin
                        n_err = asfphp_pkg::ST_FATAL;
                    end else begin
                        n_err = n_multi ? asfphp_pkg::ST_FATAL : asfphp_pkg::ST_RECOVERABLE;
                    end
                    n_phase = asfphp_pkg::PH_DONE;
                end else begin
                    n_fid   = bf_id;
                    n_fbl   = flen;
                    n_acc   = 32'd0;
                    n_shift = 2'd0;
                    n_phase = asfphp_pkg::PH_VAR;
                end
            end
            if (do_end) begin
                do_end = 1'b0;
                case (end_id)
                    asfphp_pkg::FLD_PKTLEN: begin
                        n_hf0    = end_v;
                        do_begin = 1'b1;
                        bf_id    = asfphp_pkg::FLD_SEQ;
                    end
                    asfphp_pkg::FLD_SEQ: begin
                        do_begin = 1'b1;
                        bf_id    = asfphp_pkg::FLD_PAD;
                    end
                    asfphp_pkg::FLD_PAD: begin
                        n_hf1 = end_v;
                        if (CW'(n_left) < CW'(asfphp_pkg::SEND_BYTES)) begin
                            n_err   = asfphp_pkg::ST_FATAL;
                            n_phase = asfphp_pkg::PH_DONE;
                        end else begin
                            n_skip  = LW'(asfphp_pkg::SEND_BYTES);
                            n_phase = asfphp_pkg::PH_SEND;
                        end
                    end
                    asfphp_pkg::FLD_MONUM: begin
                        n_hf2    = end_v;
                        do_begin = 1'b1;
                        bf_id    = asfphp_pkg::FLD_MOOFF;
                    end
                    asfphp_pkg::FLD_MOOFF: begin
                        n_hf3    = end_v;
                        do_begin = 1'b1;
                        bf_id    = asfphp_pkg::FLD_REPLEN;
                    end
                    asfphp_pkg::FLD_REPLEN: begin
                        n_hf4 = LW'(end_v);
                        if (CW'(n_left) < CW'(end_v)) begin
                            n_err   = n_multi ? asfphp_pkg::ST_FATAL : asfphp_pkg::ST_RECOVERABLE;
                            n_phase = asfphp_pkg::PH_DONE;
                        end else if (end_v == 32'd0) begin
                            do_after_rep = 1'b1;
                        end else begin
                            n_skip  = LW'(end_v);
                            n_phase = asfphp_pkg::PH_REP;
                        end
                    end
                    default: begin
                        n_hf5 = LW'(end_v);
                        if (CW'(n_left) < CW'(end_v)) begin
                            n_err   = n_multi ? asfphp_pkg::ST_FATAL : asfphp_pkg::ST_RECOVERABLE;
                            n_phase = asfphp_pkg::PH_DONE;
                        end else begin
                            do_body = 1'b1;
                        end
                    end
                endcase
            end
            if (do_after_rep) begin
                do_after_rep = 1'b0;
                if (n_left == '0) begin
                    n_err   = n_multi ? asfphp_pkg::ST_FATAL : asfphp_pkg::ST_RECOVERABLE;
                    n_phase = asfphp_pkg::PH_DONE;
                end else if (n_multi) begin
                    do_begin = 1'b1;
                    bf_id    = asfphp_pkg::FLD_PLEN;
                end else begin
                    n_hf5   = n_left;
                    do_body = 1'b1;
                end
            end
        end

        if (do_body) begin
            if (n_hf4 == LW'(1)) begin
                // Compressed payload: the object offset field carries the base time.
                n_subt = asfphp_pkg::after_preroll(n_hf3, r_preroll);
                if (n_hf5 == '0) begin
                    do_next = 1'b1;
                end else begin
                    n_phase = asfphp_pkg::PH_SUBLEN;
                end
            end else if (n_hf4 != '0 && n_hf4 < LW'(8)) begin
                n_err   = n_multi ? asfphp_pkg::ST_FATAL : asfphp_pkg::ST_RECOVERABLE;
                n_phase = asfphp_pkg::PH_DONE;
            end else if (n_hf5 == '0) begin
                do_next = 1'b1;
            end else begin
                if (n_hf4 != '0) begin
                    e_size   = {n_rep[3], n_rep[2], n_rep[1], n_rep[0]};
                    e_time   = asfphp_pkg::after_preroll({n_rep[7], n_rep[6], n_rep[5], n_rep[4]},
                                                         r_preroll);
                    e_tvalid = 1'b1;
                end
                e_emit  = 1'b1;
                e_dur   = 8'd0;
                e_len   = n_hf5;
                n_skip  = n_hf5;
                n_phase = asfphp_pkg::PH_DATA;
            end
        end

        if (do_next) begin
            n_index = n_index + 1'b1;
            if (n_index >= n_count || n_index == '0) begin
                n_phase = asfphp_pkg::PH_DONE;
            end else begin
                do_start = 1'b1;
            end
        end

        if (do_start) begin
            if (n_left == '0) begin
                n_err   = n_multi ? asfphp_pkg::ST_FATAL : asfphp_pkg::ST_RECOVERABLE;
                n_phase = asfphp_pkg::PH_DONE;
            end else begin
                n_phase = asfphp_pkg::PH_STREAM;
            end
        end

        if (proc && n_bpos == n_last) begin
            e_status = 1'b1;
            n_phase  = asfphp_pkg::PH_IDLE;
        end
    end

    // Result word: a status on the last byte replaces any descriptor.
    always_comb begin
        pos_next = CW'(n_bpos) + CW'(1);
        n_out    = '0;
        if (e_status) begin
            n_out.result_kind = asfphp_pkg::KIND_STATUS;
            n_out.status      = n_err;
        end else begin
            n_out.result_kind    = asfphp_pkg::KIND_DESCRIPTOR;
            n_out.stream_number  = 7'(n_stream & asfphp_pkg::STREAM_MASK);
            n_out.key_frame      = n_stream[7];
            n_out.object_number  = n_hf2;
            n_out.object_offset  = n_hf3;
            n_out.object_size    = e_size;
            n_out.time_ms        = e_time;
            n_out.time_valid     = e_tvalid;
            n_out.duration_ms    = e_dur;
            n_out.payload_start  = pos_next[15:0];
            n_out.payload_length = 16'(e_len);
            n_out.status         = asfphp_pkg::ST_NONE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= asfphp_pkg::PH_IDLE;
            r_bpos      <= '0;
            r_last      <= '0;
            r_err       <= asfphp_pkg::ST_NONE;
            r_out_valid <= 1'b0;
            r_nominal   <= 16'd0;
            r_preroll   <= 32'd0;
        end else begin
            r_phase <= n_phase;
            r_bpos  <= n_bpos;
            r_last  <= n_last;
            r_err   <= n_err;
            if (in_acc && (e_emit || e_status)) begin
                r_out_valid <= 1'b1;
            end else if (!i_out_stall) begin
                r_out_valid <= 1'b0;
            end
            if (i_cfg_we) begin
                case (i_cfg_index)
                    asfphp_pkg::CFG_NOMINAL_SIZE: r_nominal <= i_cfg_wdata[15:0];
                    asfphp_pkg::CFG_PREROLL:      r_preroll <= i_cfg_wdata;
                    default: begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_fid    <= n_fid;    r_left   <= n_left;   r_skip   <= n_skip;
        r_acc    <= n_acc;    r_fbl    <= n_fbl;    r_shift  <= n_shift;
        r_lflags <= n_lflags; r_pflags <= n_pflags; r_count  <= n_count;
        r_index  <= n_index;  r_hf0    <= n_hf0;    r_hf1    <= n_hf1;
        r_hf2    <= n_hf2;    r_hf3    <= n_hf3;    r_hf4    <= n_hf4;
        r_hf5    <= n_hf5;    r_rep    <= n_rep;    r_subt   <= n_subt;
        r_stream <= n_stream; r_multi  <= n_multi;  r_mlt    <= n_mlt;
        if (in_acc && (e_emit || e_status)) begin
            r_out <= n_out;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_word  = r_out;

    a_status_ends_buffer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_acc && e_status) |=> (r_phase == asfphp_pkg::PH_IDLE))
        else $error("parser not idle after a status word");

    a_idle_at_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == asfphp_pkg::PH_IDLE) |-> (r_bpos == r_last))
        else $error("idle parser with byte position off the buffer end");

    a_var_has_bytes: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == asfphp_pkg::PH_VAR) |-> (r_fbl != 3'd0))
        else $error("field read with no bytes left");

    a_status_code: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.result_kind == asfphp_pkg::KIND_STATUS)
        |-> (o_out_word.status != 2'd3))
        else $error("undefined status code");

    a_desc_no_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_out_word.result_kind == asfphp_pkg::KIND_DESCRIPTOR)
        |-> (o_out_word.status == asfphp_pkg::ST_NONE && o_out_word.payload_length != 16'd0))
        else $error("descriptor with status or empty payload");

endmodule

`default_nettype wire

// ----- verif/asf_packet_header_parser_top_tb.sv -----
// Self-checking testbench for the ASF data packet header parser.
// Depends on asfphp_pkg and asf_packet_header_parser_top; needs nothing else.
// A behavioral predictor follows every accepted byte; descriptors and statuses are checked.
`default_nettype none

module asf_packet_header_parser_top_tb;

    logic                  i_clk = 1'b0;
    logic                  i_rst_n = 1'b0;
    logic                  i_in_valid = 1'b0;
    logic                  i_out_stall = 1'b0;
    logic                  i_cfg_we = 1'b0;
    logic [1:0]            i_cfg_index = '0;
    logic [31:0]           i_cfg_wdata = '0;
    asfphp_pkg::t_in_word  i_in_word = '0;
    logic                  o_in_stall;
    logic                  o_out_valid;
    asfphp_pkg::t_out_word o_out_word;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    asf_packet_header_parser_top DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_word   (i_in_word),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_word  (o_out_word),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_wdata (i_cfg_wdata)
    );

    // Parser state as the predictor sees it.
    asfphp_pkg::t_phase    ps_phase = asfphp_pkg::PH_IDLE;
    logic [15:0]           ps_pos = '0;
    logic [15:0]           ps_last = '0;
    logic [31:0]           ps_left = '0;
    logic [31:0]           ps_acc = '0;
    logic [31:0]           ps_skip = '0;
    int                    ps_fbytes = 0;
    int                    ps_shift = 0;
    logic [7:0]            ps_lflags = '0;
    logic [7:0]            ps_pflags = '0;
    logic [7:0]            ps_stream = '0;
    int                    ps_count = 0;
    int                    ps_index = 0;
    logic [31:0]           ps_hdr [6] = '{default: '0};
    logic [7:0]            ps_rep [8] = '{default: '0};
    logic [31:0]           ps_subt = '0;
    logic [1:0]            ps_err = asfphp_pkg::ST_NONE;
    bit                    ps_multi = 1'b0;
    logic [1:0]            ps_mlt = '0;
    asfphp_pkg::t_field    ps_fid = asfphp_pkg::FLD_PKTLEN;
    logic [15:0]           cfg_nominal = '0;
    logic [31:0]           cfg_preroll = '0;
    asfphp_pkg::t_out_word ps_out;
    bit                    ps_out_v;

    asfphp_pkg::t_out_word results_due [$];
    asfphp_pkg::t_in_word  byte_stream [$];
    int          errors = 0;
    int          idle_mode = 0;
    int          hold_gen = 0;
    int          hold_seen = 0;
    int          hold_left = 0;

    function automatic void pkt_fail(input logic [1:0] code);
        ps_err = code;
        ps_phase = asfphp_pkg::PH_DONE;
    endfunction

    function automatic void pay_fail();
        pkt_fail(ps_multi ? asfphp_pkg::ST_FATAL : asfphp_pkg::ST_RECOVERABLE);
    endfunction

    function automatic logic [31:0] rep_le(input int off);
        return {ps_rep[off + 3], ps_rep[off + 2], ps_rep[off + 1], ps_rep[off]};
    endfunction

    function automatic logic [31:0] less_preroll(input logic [31:0] t);
        return (t < cfg_preroll) ? 32'd0 : t - cfg_preroll;
    endfunction

    function automatic void emit_desc(input logic [31:0] size, input logic [31:0] t,
                                      input logic valid, input logic [7:0] dur,
                                      input logic [31:0] len);
        ps_out = '0;
        ps_out.result_kind = asfphp_pkg::KIND_DESCRIPTOR;
        ps_out.stream_number = ps_stream[6:0];
        ps_out.key_frame = ps_stream[7];
        ps_out.object_number = ps_hdr[2];
        ps_out.object_offset = ps_hdr[3];
        ps_out.object_size = size;
        ps_out.time_ms = t;
        ps_out.time_valid = valid;
        ps_out.duration_ms = dur;
        ps_out.payload_start = ps_pos + 16'd1;
        ps_out.payload_length = len[15:0];
        ps_out_v = 1'b1;
    endfunction

    function automatic void start_payload();
        if (ps_left < 1) pay_fail();
        else ps_phase = asfphp_pkg::PH_STREAM;
    endfunction

    function automatic void next_payload();
        ps_index = (ps_index + 1) & 63;
        if (ps_index >= ps_count || ps_index == 0) ps_phase = asfphp_pkg::PH_DONE;
        else start_payload();
    endfunction

    function automatic void payload_body();
        logic [31:0] plen;
        logic [31:0] rlen;
        logic [31:0] size;
        logic [31:0] t;
        logic        valid;
        plen = ps_hdr[5];
        rlen = ps_hdr[4];
        size = '0;
        t = '0;
        valid = 1'b0;
        if (rlen == 1) begin
            // Compressed payload: sub-payload times start at the object offset.
            ps_subt = less_preroll(ps_hdr[3]);
            if (plen == 0) next_payload();
            else ps_phase = asfphp_pkg::PH_SUBLEN;
            return;
        end
        if (rlen >= 8) begin
            size = rep_le(0);
            t = less_preroll(rep_le(4));
            valid = 1'b1;
        end else if (rlen != 0) begin
            pay_fail();
            return;
        end
        if (plen == 0) begin
            next_payload();
            return;
        end
        emit_desc(size, t, valid, 8'd0, plen);
        ps_skip = plen;
        ps_phase = asfphp_pkg::PH_DATA;
    endfunction

    function automatic void after_sub();
        logic [31:0] d;
        d = {24'd0, ps_rep[0]};
        ps_subt = (ps_subt > 32'hFFFF_FFFF - d) ? 32'hFFFF_FFFF : ps_subt + d;
        if (ps_hdr[5] == 0) next_payload();
        else ps_phase = asfphp_pkg::PH_SUBLEN;
    endfunction

    function automatic void after_header();
        logic [31:0] pad;
        logic [31:0] plen;
        logic [31:0] need;
        pad = ps_hdr[1];
        plen = ps_hdr[0];
        if (ps_left < pad) begin
            pkt_fail(asfphp_pkg::ST_RECOVERABLE);
            return;
        end
        ps_left = ps_left - pad;
        // Implicit padding applies when a nonzero packet length is shorter than nominal and no padding length is given.
        if (plen != 0 && pad == 0 && plen < {16'd0, cfg_nominal}) begin
            need = {16'd0, cfg_nominal} - plen;
            if (ps_left < need) begin
                pkt_fail(asfphp_pkg::ST_RECOVERABLE);
                return;
            end
            ps_left = ps_left - need;
        end
        if (ps_lflags[0]) begin
            if (ps_left < 1) pkt_fail(asfphp_pkg::ST_RECOVERABLE);
            else ps_phase = asfphp_pkg::PH_COUNT;
        end else begin
            ps_multi = 1'b0;
            ps_count = 1;
            ps_index = 0;
            start_payload();
        end
    endfunction

    function automatic void after_rep();
        if (ps_left == 0) begin
            pay_fail();
        end else if (ps_multi) begin
            begin_field(asfphp_pkg::FLD_PLEN);
        end else begin
            ps_hdr[5] = ps_left;
            payload_body();
        end
    endfunction

    function automatic void end_field(input asfphp_pkg::t_field id, input logic [31:0] v);
        case (id)
            asfphp_pkg::FLD_PKTLEN: begin
                ps_hdr[0] = v;
                begin_field(asfphp_pkg::FLD_SEQ);
            end
            asfphp_pkg::FLD_SEQ: begin_field(asfphp_pkg::FLD_PAD);
            asfphp_pkg::FLD_PAD: begin
                ps_hdr[1] = v;
                if (ps_left < asfphp_pkg::SEND_BYTES) begin
                    pkt_fail(asfphp_pkg::ST_FATAL);
                end else begin
                    ps_skip = asfphp_pkg::SEND_BYTES;
                    ps_phase = asfphp_pkg::PH_SEND;
                end
            end
            asfphp_pkg::FLD_MONUM: begin
                ps_hdr[2] = v;
                begin_field(asfphp_pkg::FLD_MOOFF);
            end
            asfphp_pkg::FLD_MOOFF: begin
                ps_hdr[3] = v;
                begin_field(asfphp_pkg::FLD_REPLEN);
            end
            asfphp_pkg::FLD_REPLEN: begin
                ps_hdr[4] = v;
                if (ps_left < v) begin
                    pay_fail();
                end else if (v == 0) begin
                    after_rep();
                end else begin
                    ps_skip = v;
                    ps_phase = asfphp_pkg::PH_REP;
                end
            end
            default: begin
                ps_hdr[5] = v;
                if (ps_left < v) pay_fail();
                else payload_body();
            end
        endcase
    endfunction

    function automatic void begin_field(input asfphp_pkg::t_field id);
        logic [1:0] code;
        int         len;
        case (id)
            asfphp_pkg::FLD_PKTLEN: code = ps_lflags[6:5];
            asfphp_pkg::FLD_SEQ:    code = ps_lflags[2:1];
            asfphp_pkg::FLD_PAD:    code = ps_lflags[4:3];
            asfphp_pkg::FLD_MONUM:  code = ps_pflags[5:4];
            asfphp_pkg::FLD_MOOFF:  code = ps_pflags[3:2];
            asfphp_pkg::FLD_REPLEN: code = ps_pflags[1:0];
            default:                code = ps_mlt;
        endcase
        len = (code == 2'd3) ? 4 : int'(code);
        if (len == 0) begin
            end_field(id, 32'd0);
        end else if (ps_left < len) begin
            if (id == asfphp_pkg::FLD_PKTLEN || id == asfphp_pkg::FLD_SEQ ||
                id == asfphp_pkg::FLD_PAD) pkt_fail(asfphp_pkg::ST_FATAL);
            else pay_fail();
        end else begin
            ps_fid = id;
            ps_fbytes = len;
            ps_acc = '0;
            ps_shift = 0;
            ps_phase = asfphp_pkg::PH_VAR;
        end
    endfunction

    function automatic void consume(input logic [7:0] b);
        logic [31:0] idx;
        if (ps_phase != asfphp_pkg::PH_EC && ps_left > 0) ps_left = ps_left - 1;
        case (ps_phase)
            asfphp_pkg::PH_EC: begin
                ps_skip = ps_skip - 1;
                if (ps_skip == 0) ps_phase = asfphp_pkg::PH_FLAGS1;
            end
            asfphp_pkg::PH_FLAGS1: begin
                ps_lflags = b;
                ps_phase = asfphp_pkg::PH_PROP;
            end
            asfphp_pkg::PH_PROP: begin
                ps_pflags = b;
                begin_field(asfphp_pkg::FLD_PKTLEN);
            end
            asfphp_pkg::PH_VAR: begin
                ps_acc = ps_acc | ({24'd0, b} << ps_shift);
                ps_shift = ps_shift + 8;
                ps_fbytes = ps_fbytes - 1;
                if (ps_fbytes == 0) end_field(ps_fid, ps_acc);
            end
            asfphp_pkg::PH_SEND: begin
                ps_skip = ps_skip - 1;
                if (ps_skip == 0) after_header();
            end
            asfphp_pkg::PH_COUNT: begin
                ps_count = int'(b & asfphp_pkg::COUNT_MASK);
                ps_mlt = b[7:6];
                ps_multi = 1'b1;
                ps_index = 0;
                if (ps_count == 0) ps_phase = asfphp_pkg::PH_DONE;
                else start_payload();
            end
            asfphp_pkg::PH_STREAM: begin
                ps_stream = b;
                begin_field(asfphp_pkg::FLD_MONUM);
            end
            asfphp_pkg::PH_REP: begin
                idx = ps_hdr[4] - ps_skip;
                if (idx < 8) ps_rep[idx[2:0]] = b;
                ps_skip = ps_skip - 1;
                if (ps_skip == 0) after_rep();
            end
            asfphp_pkg::PH_DATA: begin
                ps_skip = ps_skip - 1;
                if (ps_skip == 0) next_payload();
            end
            asfphp_pkg::PH_SUBLEN: begin
                ps_hdr[5] = ps_hdr[5] - 1;
                if (ps_hdr[5] < {24'd0, b}) begin
                    pay_fail();
                end else if (b > 0) begin
                    emit_desc(32'd0, ps_subt, 1'b1, ps_rep[0], {24'd0, b});
                    ps_skip = {24'd0, b};
                    ps_phase = asfphp_pkg::PH_SUBDATA;
                end else begin
                    after_sub();
                end
            end
            asfphp_pkg::PH_SUBDATA: begin
                ps_hdr[5] = ps_hdr[5] - 1;
                ps_skip = ps_skip - 1;
                if (ps_skip == 0) after_sub();
            end
            default: ;
        endcase
    endfunction

    function automatic void start_buffer(input logic [7:0] b, input logic [15:0] blen);
        int ec_len;
        ps_pos = '0;
        ps_last = (blen == 0) ? 16'd0 : blen - 16'd1;
        ps_err = asfphp_pkg::ST_NONE;
        ps_left = '0;
        ps_skip = '0;
        ps_multi = 1'b0;
        ps_count = 0;
        ps_index = 0;
        if (blen < asfphp_pkg::MIN_BUFFER) begin
            pkt_fail(asfphp_pkg::ST_RECOVERABLE);
            return;
        end
        if ((b & asfphp_pkg::EC_PRESENT_MASK) != 0) begin
            ec_len = ((b & asfphp_pkg::EC_TYPE_MASK) == 0) ?
                     int'(b & asfphp_pkg::EC_LEN_MASK) : 2;
            if (int'(blen) <= 1 + ec_len + 8) begin
                pkt_fail(asfphp_pkg::ST_FATAL);
                return;
            end
            ps_left = {16'd0, blen} - 32'd1 - ec_len;
            if (ec_len == 0) begin
                ps_phase = asfphp_pkg::PH_FLAGS1;
            end else begin
                ps_skip = ec_len;
                ps_phase = asfphp_pkg::PH_EC;
            end
        end else begin
            ps_left = {16'd0, blen};
            ps_phase = asfphp_pkg::PH_FLAGS1;
            consume(b);
        end
    endfunction

    // Advances the predictor by one accepted word; ps_out_v tells if a result is due.
    function automatic void parse_word(input asfphp_pkg::t_in_word w);
        ps_out_v = 1'b0;
        if (w.first_byte) begin
            start_buffer(w.data_byte, w.buffer_length);
        end else if (ps_phase == asfphp_pkg::PH_IDLE) begin
            return;
        end else begin
            ps_pos = ps_pos + 16'd1;
            consume(w.data_byte);
        end
        if (ps_pos == ps_last) begin
            ps_out = '0;
            ps_out.result_kind = asfphp_pkg::KIND_STATUS;
            ps_out.status = ps_err;
            ps_out_v = 1'b1;
            ps_phase = asfphp_pkg::PH_IDLE;
        end
    endfunction

    function automatic bit idle_roll(input bit rx_side);
        if (idle_mode == 3) return $urandom_range(99) < 7;
        if ((idle_mode == 1 && !rx_side) || (idle_mode == 2 && rx_side))
            return $urandom_range(99) < 80;
        return 1'b0;
    endfunction

    task automatic send_word(input asfphp_pkg::t_in_word w, input bit typed,
                             input logic [1:0] st);
        asfphp_pkg::t_out_word fixed;
        i_in_word <= w;
        i_in_valid <= 1'b1;
        do @(posedge i_clk); while (o_in_stall);
        parse_word(w);
        if (typed) begin
            fixed = '0;
            fixed.result_kind = asfphp_pkg::KIND_STATUS;
            fixed.status = st;
            results_due.push_back(fixed);
        end else if (ps_out_v) begin
            results_due.push_back(ps_out);
        end
        if (idle_roll(1'b0)) begin
            i_in_valid <= 1'b0;
            @(posedge i_clk);
            while (idle_roll(1'b0)) @(posedge i_clk);
        end
    endtask

    // Leaves the write enable high; the caller drops it after the last write.
    task automatic write_reg(input asfphp_pkg::t_cfg_reg idx, input logic [31:0] val);
        i_cfg_we <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_wdata <= val;
        @(posedge i_clk);
        if (idx == asfphp_pkg::CFG_NOMINAL_SIZE) cfg_nominal = val[15:0];
        else cfg_preroll = val;
    endtask

    task automatic drain_and_configure(input logic [15:0] nominal, input logic [31:0] preroll);
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        // A byte with no result may still be in flight behind the last result.
        repeat (4) @(posedge i_clk);
        write_reg(asfphp_pkg::CFG_NOMINAL_SIZE, {16'd0, nominal});
        write_reg(asfphp_pkg::CFG_PREROLL, preroll);
        i_cfg_we <= 1'b0;
    endtask

    function automatic void push_byte(input logic [7:0] b);
        asfphp_pkg::t_in_word w;
        w = '0;
        w.data_byte = b;
        byte_stream.push_back(w);
    endfunction

    // Little-endian variable-length field of 0, 1, 2 or 4 bytes.
    function automatic void push_var(input logic [31:0] v, input logic [1:0] code);
        int n;
        n = (code == 2'd3) ? 4 : int'(code);
        for (int i = 0; i < n; i++) push_byte(v[8 * i +: 8]);
    endfunction

    function automatic void build_payload(input bit multi, input logic [1:0] lt,
                                          input logic [7:0] pf);
        logic [7:0]  body [$];
        logic [31:0] rlen;
        logic [31:0] mooff;
        int          sel;
        int          k;
        sel = $urandom_range(9);
        push_byte(8'($urandom));
        push_var($urandom, pf[5:4]);
        if (sel >= 4 && sel <= 6) rlen = 1;
        else if (sel == 7) rlen = 0;
        else if (sel == 8) rlen = $urandom_range(12);
        else rlen = 8;
        if (pf[1:0] == 2'd0) rlen = 0;
        mooff = $urandom;
        // Compressed payloads near the top of the time range saturate.
        if (rlen == 1 && $urandom_range(4) == 0) mooff = 32'hFFFF_FFF0;
        else if (rlen == 1) mooff = $urandom_range(100000);
        push_var(mooff, pf[3:2]);
        push_var(rlen, pf[1:0]);
        for (int i = 0; i < int'(rlen); i++) push_byte(8'($urandom));
        if (rlen == 1) begin
            repeat ($urandom_range(1, 3)) begin
                k = $urandom_range(6);
                body.push_back(8'(k));
                repeat (k) body.push_back(8'($urandom));
            end
        end else begin
            repeat ($urandom_range(12)) body.push_back(8'($urandom));
        end
        if (multi) push_var(body.size(), lt);
        foreach (body[i]) push_byte(body[i]);
    endfunction

    function automatic void build_packet();
        int          start;
        int          npad;
        int          cnt;
        logic [7:0]  lf;
        logic [7:0]  pf;
        logic [1:0]  lt;
        logic [15:0] blen;
        start = byte_stream.size();
        if ($urandom_range(9) == 0) begin
            // Noise: loose words, some opening buffers of any length.
            repeat ($urandom_range(1, 5)) begin
                push_byte(8'($urandom));
                byte_stream[byte_stream.size() - 1].first_byte = ($urandom_range(4) == 0);
                byte_stream[byte_stream.size() - 1].buffer_length = 16'($urandom);
            end
            return;
        end
        lf = 8'($urandom);
        npad = $urandom_range(3);
        if ($urandom_range(9) < 7) begin
            push_byte(($urandom_range(9) == 0) ?
                      (8'($urandom) | asfphp_pkg::EC_PRESENT_MASK) : 8'h82);
            push_byte(8'($urandom));
            push_byte(8'($urandom));
        end else begin
            lf[7] = 1'b0;
        end
        push_byte(lf);
        if ($urandom_range(4) != 0) pf = {2'($urandom), 2'd1, 2'd3, 2'd1};
        else pf = 8'($urandom);
        push_byte(pf);
        case ($urandom_range(2))
            0: push_var(32'd0, lf[6:5]);
            1: push_var({16'd0, cfg_nominal}, lf[6:5]);
            default: push_var($urandom_range(120), lf[6:5]);
        endcase
        push_var($urandom, lf[2:1]);
        push_var(npad, lf[4:3]);
        if (lf[4:3] == 2'd0) npad = 0;
        repeat (asfphp_pkg::SEND_BYTES) push_byte(8'($urandom));
        if (lf[0]) begin
            cnt = ($urandom_range(19) == 0) ? $urandom_range(63) : $urandom_range(1, 4);
            lt = ($urandom_range(4) == 0) ? 2'($urandom) : 2'($urandom_range(1, 2));
            push_byte({lt, 6'(cnt)});
            repeat (cnt > 6 ? 6 : cnt) build_payload(1'b1, lt, pf);
        end else begin
            build_payload(1'b0, 2'd0, pf);
        end
        repeat (npad) push_byte(8'($urandom));
        blen = 16'(byte_stream.size() - start);
        if ($urandom_range(9) == 0) blen = blen + 16'($urandom_range(6)) - 16'd3;
        else if ($urandom_range(49) == 0) blen = 16'($urandom);
        byte_stream[start].first_byte = 1'b1;
        byte_stream[start].buffer_length = blen;
    endfunction

    // Output side: stall pattern and in-order comparison.
    task automatic check_field(input string nm, input logic [31:0] e, input logic [31:0] a);
        if (e !== a) begin
            $display("%0t: %s mismatch: expected %h actual %h", $time, nm, e, a);
            errors++;
        end
    endtask

    always @(posedge i_clk) begin
        asfphp_pkg::t_out_word e;
        if (i_rst_n && o_out_valid && !i_out_stall) begin
            if (results_due.size() == 0) begin
                $display("%0t: unexpected word: expected none actual %p", $time, o_out_word);
                errors++;
            end else begin
                e = results_due.pop_front();
                check_field("result_kind", e.result_kind, o_out_word.result_kind);
                check_field("stream_number", e.stream_number, o_out_word.stream_number);
                check_field("key_frame", e.key_frame, o_out_word.key_frame);
                check_field("object_number", e.object_number, o_out_word.object_number);
                check_field("object_offset", e.object_offset, o_out_word.object_offset);
                check_field("object_size", e.object_size, o_out_word.object_size);
                check_field("time_ms", e.time_ms, o_out_word.time_ms);
                check_field("time_valid", e.time_valid, o_out_word.time_valid);
                check_field("duration_ms", e.duration_ms, o_out_word.duration_ms);
                check_field("payload_start", e.payload_start, o_out_word.payload_start);
                check_field("payload_length", e.payload_length, o_out_word.payload_length);
                check_field("status", e.status, o_out_word.status);
            end
        end
        if (hold_gen != hold_seen) begin
            hold_seen = hold_gen;
            hold_left = 300;
        end
        if (hold_left > 0) begin
            hold_left = hold_left - 1;
            i_out_stall <= 1'b1;
        end else begin
            i_out_stall <= idle_roll(1'b1);
        end
    end

    typedef struct {
        logic [7:0]  b;
        bit          f;
        logic [15:0] len;
        bit          typed;
        logic [1:0]  st;
    } t_row;

    t_row rows [13];

    initial begin
        rows = '{
            '{8'h00, 1'b1, 16'd0,    1'b1, asfphp_pkg::ST_RECOVERABLE}, // zero length: one byte
            '{8'hFF, 1'b1, 16'd1,    1'b1, asfphp_pkg::ST_RECOVERABLE},
            '{8'h82, 1'b1, 16'd8,    1'b0, asfphp_pkg::ST_NONE}, // error-correction prefix too long
            '{8'h00, 1'b0, 16'd0,    1'b0, asfphp_pkg::ST_NONE},
            '{8'hFF, 1'b0, 16'd0,    1'b0, asfphp_pkg::ST_NONE},
            '{8'h55, 1'b0, 16'd0,    1'b0, asfphp_pkg::ST_NONE},
            '{8'hAA, 1'b0, 16'd0,    1'b0, asfphp_pkg::ST_NONE},
            '{8'h01, 1'b0, 16'd0,    1'b0, asfphp_pkg::ST_NONE},
            '{8'h3C, 1'b0, 16'd0,    1'b0, asfphp_pkg::ST_NONE},
            '{8'h80, 1'b0, 16'd0,    1'b1, asfphp_pkg::ST_FATAL},
            '{8'h33, 1'b0, 16'hFFFF, 1'b0, asfphp_pkg::ST_NONE}, // outside any buffer: ignored
            '{8'h00, 1'b1, 16'hFFFF, 1'b0, asfphp_pkg::ST_NONE}, // long buffer, cut off below
            '{8'h7F, 1'b0, 16'd0,    1'b0, asfphp_pkg::ST_NONE}
        };
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        foreach (rows[i]) begin
            asfphp_pkg::t_in_word w;
            w.data_byte = rows[i].b;
            w.first_byte = rows[i].f;
            w.buffer_length = rows[i].len;
            send_word(w, rows[i].typed, rows[i].st);
        end
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: drain_and_configure(16'd0, 32'd0);
                1: drain_and_configure(16'hFFFF, 32'hFFFF_FFFF);
                2: drain_and_configure(16'($urandom_range(20, 80)), $urandom_range(1000));
                default: drain_and_configure(16'($urandom), $urandom);
            endcase
            idle_mode = phase;
            // Long receiver hold-off while words keep coming, to fill the block.
            if (phase == 0) hold_gen = hold_gen + 1;
            byte_stream.delete();
            while (byte_stream.size() < 310) build_packet();
            foreach (byte_stream[i]) send_word(byte_stream[i], 1'b0, asfphp_pkg::ST_NONE);
        end
        i_in_valid <= 1'b0;
        while (results_due.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);
        if (errors == 0)
            $display("asf_packet_header_parser_top_tb: clean");
        else
            $display("asf_packet_header_parser_top_tb: errors");
        $finish;
    end

    initial begin
        #1000000;
        $display("asf_packet_header_parser_top_tb: errors");
        $finish;
    end

endmodule

`default_nettype wire
